### sv/ypb_pkg.sv
package ypb_pkg;

    localparam int FMT_W     = 3;
    localparam int PIX_W     = 14;
    localparam int ALIGN_W   = 13;
    localparam int SIZE_W    = 15;
    localparam int STRIDE_W  = 16;
    localparam int OFFS_W    = 32;
    localparam int PLANES_W  = 2;
    localparam int AREA_W    = 30;

    typedef enum logic [FMT_W-1:0] {
        FMT_I420 = 3'd0,
        FMT_NV12 = 3'd1,
        FMT_NV21 = 3'd2,
        FMT_UYVY = 3'd3,
        FMT_YUY2 = 3'd4,
        FMT_P010 = 3'd5,
        FMT_I010 = 3'd6,
        FMT_NONE = 3'd7
    } pix_fmt_t;

    // Strides chosen for the format, handed to the size stages.
    typedef struct packed {
        pix_fmt_t              fmt;
        logic [STRIDE_W-1:0]   luma;
        logic [STRIDE_W-1:0]   chroma;
        logic [SIZE_W-1:0]     aw;
        logic [SIZE_W-1:0]     ah;
    } stride_word_t;

    typedef struct packed {
        logic                  format_ok;
        logic [STRIDE_W-1:0]   luma_stride;
        logic [STRIDE_W-1:0]   first_chroma_stride;
        logic [STRIDE_W-1:0]   second_chroma_stride;
        logic [OFFS_W-1:0]     first_chroma_offset;
        logic [OFFS_W-1:0]     second_chroma_offset;
        logic [PLANES_W-1:0]   plane_count;
        logic [OFFS_W-1:0]     buffer_bytes;
    } out_word_t;

endpackage

### sv/ypb_if.sv
interface ypb_req_if;
    logic                          valid;
    logic                          ready;
    logic [ypb_pkg::FMT_W-1:0]     pixel_format;
    logic [ypb_pkg::PIX_W-1:0]     pic_width;
    logic [ypb_pkg::PIX_W-1:0]     pic_height;
    logic [ypb_pkg::ALIGN_W-1:0]   width_align;
    logic [ypb_pkg::ALIGN_W-1:0]   height_align;

    modport source (output valid, pixel_format, pic_width, pic_height, width_align,
                    height_align, input ready);
    modport sink (input valid, pixel_format, pic_width, pic_height, width_align,
                  height_align, output ready);
endinterface

interface ypb_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          format_ok;
    logic [ypb_pkg::STRIDE_W-1:0]  luma_stride;
    logic [ypb_pkg::STRIDE_W-1:0]  first_chroma_stride;
    logic [ypb_pkg::STRIDE_W-1:0]  second_chroma_stride;
    logic [ypb_pkg::OFFS_W-1:0]    first_chroma_offset;
    logic [ypb_pkg::OFFS_W-1:0]    second_chroma_offset;
    logic [ypb_pkg::PLANES_W-1:0]  plane_count;
    logic [ypb_pkg::OFFS_W-1:0]    buffer_bytes;

    modport source (output valid, format_ok, luma_stride, first_chroma_stride,
                    second_chroma_stride, first_chroma_offset, second_chroma_offset,
                    plane_count, buffer_bytes, input ready);
    modport sink (input valid, format_ok, luma_stride, first_chroma_stride,
                  second_chroma_stride, first_chroma_offset, second_chroma_offset,
                  plane_count, buffer_bytes, output ready);
endinterface

### sv/ypb_div.sv
// Restoring divider, one quotient bit per register stage.
module ypb_div #(
    parameter int DVD_W  = 14,
    parameter int DVS_W  = 13,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DVD_W-1:0]  dvd,
    input  logic [DVS_W-1:0]  dvs,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [DVD_W-1:0]  out_dvd,
    output logic [DVS_W-1:0]  out_dvs,
    output logic [DVS_W-1:0]  out_rem,
    output logic              out_q_lsb,
    output logic [SIDE_W-1:0] out_side
);

    logic              v_reg    [DVD_W];
    logic [DVD_W-1:0]  dvd_reg  [DVD_W];
    logic [DVS_W-1:0]  dvs_reg  [DVD_W];
    logic [DVS_W-1:0]  rem_reg  [DVD_W];
    logic              qb_reg   [DVD_W];
    logic [SIDE_W-1:0] side_reg [DVD_W];

    for (genvar k = 0; k < DVD_W; k++) begin : g_stage
        logic              v_in;
        logic [DVD_W-1:0]  dvd_in;
        logic [DVS_W-1:0]  dvs_in;
        logic [DVS_W-1:0]  rem_in;
        logic [SIDE_W-1:0] side_in;
        logic [DVS_W:0]    trial;
        logic [DVS_W:0]    diff;
        logic              hit;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign dvd_in  = dvd;
            assign dvs_in  = dvs;
            assign rem_in  = '0;
            assign side_in = side;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign dvd_in  = dvd_reg[k-1];
            assign dvs_in  = dvs_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial = {rem_in, dvd_in[DVD_W-1-k]};
        assign diff  = trial - {1'b0, dvs_in};
        assign hit   = (trial >= {1'b0, dvs_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dvd_reg[k]  <= dvd_in;
                dvs_reg[k]  <= dvs_in;
                rem_reg[k]  <= hit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                qb_reg[k]   <= hit;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[DVD_W-1];
    assign out_dvd   = dvd_reg[DVD_W-1];
    assign out_dvs   = dvs_reg[DVD_W-1];
    assign out_rem   = rem_reg[DVD_W-1];
    assign out_q_lsb = qb_reg[DVD_W-1];
    assign out_side  = side_reg[DVD_W-1];

endmodule

### sv/ypb_stride.sv
// Rounds the aligned width to the stride alignment and picks the strides of the format.
module ypb_stride (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  ypb_pkg::pix_fmt_t             fmt,
    input  logic [ypb_pkg::SIZE_W-1:0]    aw,
    input  logic [ypb_pkg::SIZE_W-1:0]    ah,
    input  logic [ypb_pkg::ALIGN_W-1:0]   h2,
    input  logic [ypb_pkg::ALIGN_W-1:0]   rem,
    input  logic                          q_lsb,
    output logic                          out_valid,
    output ypb_pkg::stride_word_t         out_word
);

    localparam int SW = ypb_pkg::STRIDE_W;

    logic [ypb_pkg::ALIGN_W:0] mod_sa;
    logic [SW-1:0]             aw16;
    logic [SW-1:0]             s_str;
    logic [SW-1:0]             c_p010;
    logic [SW-1:0]             l_p010;
    logic [SW-1:0]             c_i420;
    ypb_pkg::stride_word_t     word_next;
    ypb_pkg::stride_word_t     word_reg;
    logic                      valid_reg;

    // The stride alignment is twice h2, so an odd quotient adds h2 to the remainder.
    assign mod_sa = q_lsb ? ({1'b0, rem} + {1'b0, h2}) : {1'b0, rem};
    assign aw16   = {1'b0, aw};
    assign s_str  = (mod_sa == '0) ? aw16
                  : aw16 + {2'b0, h2, 1'b0} - {2'b0, mod_sa};
    assign c_p010 = (rem == '0) ? aw16 : aw16 + {3'b0, h2} - {3'b0, rem};
    assign l_p010 = {c_p010[SW-2:0], 1'b0};
    assign c_i420 = {1'b0, s_str[SW-1:1]};

    always_comb
    begin
        word_next.fmt = fmt;
        word_next.aw  = aw;
        word_next.ah  = ah;
        case (fmt)
            ypb_pkg::FMT_I420:
            begin
                word_next.luma   = s_str;
                word_next.chroma = c_i420;
            end
            ypb_pkg::FMT_NV12, ypb_pkg::FMT_NV21:
            begin
                word_next.luma   = s_str;
                word_next.chroma = s_str;
            end
            ypb_pkg::FMT_UYVY, ypb_pkg::FMT_YUY2:
            begin
                word_next.luma   = {aw, 1'b0};
                word_next.chroma = '0;
            end
            ypb_pkg::FMT_P010:
            begin
                word_next.luma   = l_p010;
                word_next.chroma = c_p010;
            end
            ypb_pkg::FMT_I010:
            begin
                word_next.luma   = l_p010;
                word_next.chroma = l_p010;
            end
            default:
            begin
                word_next.luma   = '0;
                word_next.chroma = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

### sv/ypb_size.sv
// Plane offsets and buffer size: one multiply stage, then one add and select stage.
module ypb_size (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  ypb_pkg::stride_word_t in_word,
    output logic                  out_valid,
    output ypb_pkg::out_word_t    out_word
);

    localparam int OW = ypb_pkg::OFFS_W;

    logic                          mv_reg;
    ypb_pkg::pix_fmt_t             fmt_reg;
    logic [ypb_pkg::STRIDE_W-1:0]  luma_reg;
    logic [ypb_pkg::STRIDE_W-1:0]  chroma_reg;
    logic [OW-1:0]                 o1_reg;
    logic [OW-1:0]                 cah_reg;
    logic [ypb_pkg::AREA_W-1:0]    area_reg;

    logic [OW-1:0]                 o2;
    logic [OW-1:0]                 area3;
    ypb_pkg::out_word_t            word_next;
    ypb_pkg::out_word_t            word_reg;
    logic                          fv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
            fv_reg <= 1'b0;
        end
        else if (en)
        begin
            mv_reg <= in_valid;
            fv_reg <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fmt_reg    <= in_word.fmt;
            luma_reg   <= in_word.luma;
            chroma_reg <= in_word.chroma;
            o1_reg     <= OW'(in_word.luma * in_word.ah);
            cah_reg    <= OW'(in_word.chroma * in_word.ah);
            area_reg   <= ypb_pkg::AREA_W'(in_word.aw * in_word.ah);
        end
    end

    assign o2    = o1_reg + {1'b0, cah_reg[OW-1:1]};
    assign area3 = {2'b0, area_reg} + {1'b0, area_reg, 1'b0};

    always_comb
    begin
        word_next = '0;
        case (fmt_reg)
            ypb_pkg::FMT_I420:
            begin
                word_next.format_ok            = 1'b1;
                word_next.luma_stride          = luma_reg;
                word_next.first_chroma_stride  = chroma_reg;
                word_next.second_chroma_stride = chroma_reg;
                word_next.first_chroma_offset  = o1_reg;
                word_next.second_chroma_offset = o2;
                word_next.plane_count          = 2'd3;
                word_next.buffer_bytes         = {1'b0, area3[OW-1:1]};
            end
            ypb_pkg::FMT_NV12, ypb_pkg::FMT_NV21:
            begin
                word_next.format_ok            = 1'b1;
                word_next.luma_stride          = luma_reg;
                word_next.first_chroma_stride  = chroma_reg;
                word_next.first_chroma_offset  = o1_reg;
                word_next.plane_count          = 2'd2;
                word_next.buffer_bytes         = {1'b0, area3[OW-1:1]};
            end
            ypb_pkg::FMT_UYVY, ypb_pkg::FMT_YUY2:
            begin
                word_next.format_ok            = 1'b1;
                word_next.luma_stride          = luma_reg;
                word_next.plane_count          = 2'd1;
                word_next.buffer_bytes         = {1'b0, area_reg, 1'b0};
            end
            ypb_pkg::FMT_P010:
            begin
                word_next.format_ok            = 1'b1;
                word_next.luma_stride          = luma_reg;
                word_next.first_chroma_stride  = chroma_reg;
                word_next.second_chroma_stride = chroma_reg;
                word_next.first_chroma_offset  = o1_reg;
                word_next.second_chroma_offset = o2;
                word_next.plane_count          = 2'd3;
                word_next.buffer_bytes         = area3;
            end
            ypb_pkg::FMT_I010:
            begin
                word_next.format_ok            = 1'b1;
                word_next.luma_stride          = luma_reg;
                word_next.first_chroma_stride  = chroma_reg;
                word_next.first_chroma_offset  = o1_reg;
                word_next.plane_count          = 2'd2;
                word_next.buffer_bytes         = area3;
            end
            default:
            begin
                word_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = fv_reg;
    assign out_word  = word_reg;

endmodule

### sv/ypb_skid.sv
// Output register with one skid entry; the pipeline stops only while the skid entry is full.
module ypb_skid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  ypb_pkg::out_word_t in_word,
    output logic               pipe_en,
    output logic               out_valid,
    output ypb_pkg::out_word_t out_word,
    input  logic               out_ready
);

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    ypb_pkg::out_word_t out_word_reg;
    ypb_pkg::out_word_t out_word_next;
    ypb_pkg::out_word_t skid_word_reg;
    ypb_pkg::out_word_t skid_word_next;
    logic               arrive;

    assign pipe_en = !skid_valid_reg;
    assign arrive  = in_valid && pipe_en;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (out_valid_reg && !out_ready)
        begin
            if (arrive)
            begin
                skid_valid_next = 1'b1;
                skid_word_next  = in_word;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_word_next   = skid_word_reg;
            skid_valid_next = arrive;
            skid_word_next  = in_word;
        end
        else
        begin
            out_valid_next = arrive;
            out_word_next  = in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a word while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid entry filled without an output stall");

endmodule

### sv/yuv_picture_buffer_layout.sv
// YUV picture buffer layout. Each request word carries a pixel format, a picture size and
// width and height alignments (zero means none); each response word carries the plane
// strides, the chroma plane offsets, the plane count and the total buffer size. Unsupported
// format code 7 gives format_ok low and all other fields zero. The block is a pipeline that
// takes one request word per clock cycle while the request side is not held off, and
// returns the matching responses in order. Restoring dividers give one quotient bit per
// stage: 14 stages for the width and height alignment remainders, the aligned size stage,
// 15 for the stride alignment remainder, then the rounding, multiply and select stages and
// the output register. A stalled response side fills a single skid entry before the
// request side is held off, so a response can wait while the next request is taken.
module yuv_picture_buffer_layout (
    input  logic           clk,
    input  logic           rst_n,
    ypb_req_if.sink        req,
    ypb_rsp_if.source      rsp
);

    localparam int PW = ypb_pkg::PIX_W;
    localparam int AL = ypb_pkg::ALIGN_W;
    localparam int SZ = ypb_pkg::SIZE_W;
    localparam int FW = ypb_pkg::FMT_W;

    logic                  pipe_en;

    // Width and height alignment remainders.
    logic                  dw_valid;
    logic [PW-1:0]         dw_w;
    logic [AL-1:0]         dw_wa;
    logic [AL-1:0]         dw_rem;
    logic [FW-1:0]         dw_fmt;
    logic [PW-1:0]         dh_h;
    logic [AL-1:0]         dh_ha;
    logic [AL-1:0]         dh_rem;

    // Aligned size stage.
    logic                  al_valid_reg;
    logic [SZ-1:0]         aw_reg;
    logic [SZ-1:0]         ah_reg;
    logic [AL-1:0]         h2_reg;
    logic [FW-1:0]         fmt_reg;
    logic [SZ-1:0]         aw_next;
    logic [SZ-1:0]         ah_next;
    logic [AL-1:0]         h2_next;
    logic [AL:0]           wa_inc;

    // Stride alignment remainder.
    logic                  ds_valid;
    logic [SZ-1:0]         ds_aw;
    logic [AL-1:0]         ds_h2;
    logic [AL-1:0]         ds_rem;
    logic                  ds_q_lsb;
    logic [FW+SZ-1:0]      ds_side;

    logic                  st_valid;
    ypb_pkg::stride_word_t st_word;
    logic                  sz_valid;
    ypb_pkg::out_word_t    sz_word;
    ypb_pkg::out_word_t    rsp_word;

    assign req.ready = pipe_en;

    ypb_div #(.DVD_W(PW), .DVS_W(AL), .SIDE_W(FW)) u_div_w (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (req.valid),
        .dvd       (req.pic_width),
        .dvs       (req.width_align),
        .side      (req.pixel_format),
        .out_valid (dw_valid),
        .out_dvd   (dw_w),
        .out_dvs   (dw_wa),
        .out_rem   (dw_rem),
        .out_q_lsb (),
        .out_side  (dw_fmt)
    );

    // Runs in lockstep with the width divider, so its valid bit is not needed.
    ypb_div #(.DVD_W(PW), .DVS_W(AL), .SIDE_W(1)) u_div_h (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (req.valid),
        .dvd       (req.pic_height),
        .dvs       (req.height_align),
        .side      (1'b0),
        .out_valid (),
        .out_dvd   (dh_h),
        .out_dvs   (dh_ha),
        .out_rem   (dh_rem),
        .out_q_lsb (),
        .out_side  ()
    );

    // Round up to the alignment by adding the distance to the next multiple.
    // The stride alignment is twice h2, where h2 is half the even-rounded width alignment,
    // and at least one.
    assign aw_next = ((dw_wa == '0) || (dw_rem == '0)) ? {1'b0, dw_w}
                   : {1'b0, dw_w} + {2'b0, dw_wa} - {2'b0, dw_rem};
    assign ah_next = ((dh_ha == '0) || (dh_rem == '0)) ? {1'b0, dh_h}
                   : {1'b0, dh_h} + {2'b0, dh_ha} - {2'b0, dh_rem};
    assign wa_inc  = {1'b0, dw_wa} + {{AL{1'b0}}, 1'b1};
    assign h2_next = (dw_wa == '0) ? {{(AL-1){1'b0}}, 1'b1} : wa_inc[AL:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            al_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            al_valid_reg <= dw_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            aw_reg  <= aw_next;
            ah_reg  <= ah_next;
            h2_reg  <= h2_next;
            fmt_reg <= dw_fmt;
        end
    end

    ypb_div #(.DVD_W(SZ), .DVS_W(AL), .SIDE_W(FW + SZ)) u_div_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (al_valid_reg),
        .dvd       (aw_reg),
        .dvs       (h2_reg),
        .side      ({fmt_reg, ah_reg}),
        .out_valid (ds_valid),
        .out_dvd   (ds_aw),
        .out_dvs   (ds_h2),
        .out_rem   (ds_rem),
        .out_q_lsb (ds_q_lsb),
        .out_side  (ds_side)
    );

    ypb_stride u_stride (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (ds_valid),
        .fmt       (ypb_pkg::pix_fmt_t'(ds_side[FW+SZ-1:SZ])),
        .aw        (ds_aw),
        .ah        (ds_side[SZ-1:0]),
        .h2        (ds_h2),
        .rem       (ds_rem),
        .q_lsb     (ds_q_lsb),
        .out_valid (st_valid),
        .out_word  (st_word)
    );

    ypb_size u_size (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (st_valid),
        .in_word   (st_word),
        .out_valid (sz_valid),
        .out_word  (sz_word)
    );

    ypb_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sz_valid),
        .in_word   (sz_word),
        .pipe_en   (pipe_en),
        .out_valid (rsp.valid),
        .out_word  (rsp_word),
        .out_ready (rsp.ready)
    );

    assign rsp.format_ok            = rsp_word.format_ok;
    assign rsp.luma_stride          = rsp_word.luma_stride;
    assign rsp.first_chroma_stride  = rsp_word.first_chroma_stride;
    assign rsp.second_chroma_stride = rsp_word.second_chroma_stride;
    assign rsp.first_chroma_offset  = rsp_word.first_chroma_offset;
    assign rsp.second_chroma_offset = rsp_word.second_chroma_offset;
    assign rsp.plane_count          = rsp_word.plane_count;
    assign rsp.buffer_bytes         = rsp_word.buffer_bytes;

    a_unsupported_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.format_ok) |-> (rsp.plane_count == 2'd0
            && rsp.buffer_bytes == '0 && rsp.luma_stride == '0))
        else $error("unsupported format word carries nonzero fields");

    a_supported_planes: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.format_ok) |-> (rsp.plane_count != 2'd0))
        else $error("supported format word reports no planes");

    a_packed_no_chroma: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.plane_count == 2'd1) |-> (rsp.first_chroma_stride == '0
            && rsp.first_chroma_offset == '0 && rsp.second_chroma_offset == '0))
        else $error("packed format word carries chroma plane fields");

endmodule

### tb/ypb_tb_if.sv
`timescale 1ns / 1ps

// Request fields as the testbench builds them before driving the request interface.
package ypb_tb_types;

    typedef struct packed {
        logic [ypb_pkg::FMT_W-1:0]   fmt;
        logic [ypb_pkg::PIX_W-1:0]   width;
        logic [ypb_pkg::PIX_W-1:0]   height;
        logic [ypb_pkg::ALIGN_W-1:0] walign;
        logic [ypb_pkg::ALIGN_W-1:0] halign;
    } layout_req_t;

endpackage

### tb/tb_yuv_picture_buffer_layout.sv
`timescale 1ns / 1ps

module tb_yuv_picture_buffer_layout;

    logic clk;
    logic rst_n;

    ypb_req_if req_bus ();
    ypb_rsp_if rsp_bus ();

    yuv_picture_buffer_layout u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus.sink),
        .rsp   (rsp_bus.source)
    );

    // Clock with a period of 8 ns.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    ypb_pkg::out_word_t layout_queue[$];
    int        error_count;
    int        words_sent;
    int        words_checked;
    int        unsupported_seen;
    bit        quiet_phase;
    bit        hold_rsp;

    // Rounds x up to a multiple of a; an alignment of zero leaves x as it is.
    function automatic longint unsigned round_to(longint unsigned x, longint unsigned a);
        if (a == 0)
            return x;
        return ((x + a - 1) / a) * a;
    endfunction

    // Computes the expected plane layout for one request word.
    function automatic ypb_pkg::out_word_t plane_layout(ypb_tb_types::layout_req_t r);
        ypb_pkg::out_word_t res;
        longint unsigned bpp, aw, ah, sa, s, c1, c2, o1, o2, planes, bytes;
        res = '0;
        c1 = 0;
        c2 = 0;
        o1 = 0;
        o2 = 0;
        case (ypb_pkg::pix_fmt_t'(r.fmt))
            ypb_pkg::FMT_I420, ypb_pkg::FMT_NV12, ypb_pkg::FMT_NV21: bpp = 12;
            ypb_pkg::FMT_UYVY, ypb_pkg::FMT_YUY2:                    bpp = 16;
            ypb_pkg::FMT_P010, ypb_pkg::FMT_I010:                    bpp = 24;
            default:                                                 bpp = 0;
        endcase
        if (bpp == 0)
            return res;
        aw = round_to(r.width, r.walign);
        ah = round_to(r.height, r.halign);
        sa = (r.walign < 2) ? 2 : round_to(r.walign, 2);
        s  = round_to(aw, sa);
        case (ypb_pkg::pix_fmt_t'(r.fmt))
            ypb_pkg::FMT_NV12, ypb_pkg::FMT_NV21:
            begin
                c1 = s;
                o1 = s * ah;
                planes = 2;
            end
            ypb_pkg::FMT_I420:
            begin
                c1 = round_to(s / 2, sa / 2);
                c2 = c1;
                o1 = s * ah;
                o2 = o1 + (c2 * ah) / 2;
                planes = 3;
            end
            ypb_pkg::FMT_P010:
            begin
                c1 = round_to(aw, sa / 2);
                c2 = c1;
                s  = round_to(aw * 2, sa);
                o1 = s * ah;
                o2 = o1 + (c1 * ah) / 2;
                planes = 3;
            end
            ypb_pkg::FMT_I010:
            begin
                s  = round_to(aw * 2, sa);
                c1 = s;
                o1 = s * ah;
                planes = 2;
            end
            default:
            begin
                s = (aw * bpp) / 8;
                planes = 1;
            end
        endcase
        bytes = (aw * ah * bpp) / 8;
        res.format_ok            = 1'b1;
        res.luma_stride          = s[15:0];
        res.first_chroma_stride  = c1[15:0];
        res.second_chroma_stride = c2[15:0];
        res.first_chroma_offset  = o1[31:0];
        res.second_chroma_offset = o2[31:0];
        res.plane_count          = planes[1:0];
        res.buffer_bytes         = bytes[31:0];
        return res;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("mismatch on word %0d: %s got %0h expected %0h", words_checked, field, got,
                 want);
        error_count++;
    endtask

    // Offers one request word, with a random gap first unless idling is off, and waits
    // until it is accepted. The expected layout is queued at acceptance.
    task automatic send_request(ypb_tb_types::layout_req_t r);
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.pixel_format <= r.fmt;
        req_bus.pic_width    <= r.width;
        req_bus.pic_height   <= r.height;
        req_bus.width_align  <= r.walign;
        req_bus.height_align <= r.halign;
        do
            @(posedge clk);
        while (!req_bus.ready);
        layout_queue.push_back(plane_layout(r));
        if (ypb_pkg::pix_fmt_t'(r.fmt) == ypb_pkg::FMT_NONE)
            unsupported_seen++;
        words_sent++;
    endtask

    // Lowers valid and waits on the clock so the next word starts in a fresh time step.
    task automatic drop_valid();
        req_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic ypb_tb_types::layout_req_t make_req(int f, int w, int h, int wa,
                                                           int ha);
        ypb_tb_types::layout_req_t r;
        r.fmt    = ypb_pkg::FMT_W'(f);
        r.width  = ypb_pkg::PIX_W'(w);
        r.height = ypb_pkg::PIX_W'(h);
        r.walign = ypb_pkg::ALIGN_W'(wa);
        r.halign = ypb_pkg::ALIGN_W'(ha);
        return r;
    endfunction

    // Random request with field values biased toward the usual power-of-two alignments.
    function automatic ypb_tb_types::layout_req_t random_req();
        ypb_tb_types::layout_req_t r;
        r.fmt    = ypb_pkg::FMT_W'($urandom_range(0, 7));
        r.width  = ($urandom_range(0, 3) == 0) ? ypb_pkg::PIX_W'($urandom_range(0, 16383))
                                                : ypb_pkg::PIX_W'($urandom_range(0, 4096));
        r.height = ($urandom_range(0, 3) == 0) ? ypb_pkg::PIX_W'($urandom_range(0, 16383))
                                                : ypb_pkg::PIX_W'($urandom_range(0, 2304));
        case ($urandom_range(0, 3))
            0: r.walign = ypb_pkg::ALIGN_W'($urandom_range(0, 8191));
            1: r.walign = '0;
            default: r.walign = ypb_pkg::ALIGN_W'(1 << $urandom_range(0, 12));
        endcase
        case ($urandom_range(0, 3))
            0: r.halign = ypb_pkg::ALIGN_W'($urandom_range(0, 8191));
            1: r.halign = '0;
            default: r.halign = ypb_pkg::ALIGN_W'(1 << $urandom_range(0, 12));
        endcase
        return r;
    endfunction

    // Every format at a common size and at the largest size, odd alignments, zero sizes and
    // alignments beyond 4096, plus the unsupported code.
    task automatic test_directed();
        for (int f = 0; f < 8; f++)
        begin
            send_request(make_req(f, 1920, 1080, 16, 16));
            send_request(make_req(f, 16383, 16383, 8191, 8191));
        end
        send_request(make_req(ypb_pkg::FMT_I420, 0, 0, 0, 0));
        send_request(make_req(ypb_pkg::FMT_NV12, 0, 720, 1, 1));
        send_request(make_req(ypb_pkg::FMT_P010, 1279, 0, 3, 7));
        send_request(make_req(ypb_pkg::FMT_I010, 16383, 16383, 0, 0));
        send_request(make_req(ypb_pkg::FMT_YUY2, 1, 1, 4096, 4096));
        send_request(make_req(ypb_pkg::FMT_I420, 5461, 10922, 5461, 2730));
        send_request(make_req(ypb_pkg::FMT_NONE, 0, 0, 0, 0));
        drop_valid();
    endtask

    // Receiver holds off for a long stretch while requests keep coming, so the pipeline
    // fills up and back-pressures the request side.
    task automatic test_backpressure();
        hold_rsp = 1'b1;
        for (int i = 0; i < 60; i++)
            send_request(random_req());
        drop_valid();
        hold_rsp = 1'b0;
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_request(random_req());
        drop_valid();
    endtask

    // Full-rate stretch with no idling on either side.
    task automatic test_streaming(int count);
        quiet_phase = 1'b1;
        for (int i = 0; i < count; i++)
            send_request(random_req());
        drop_valid();
    endtask

    // Response side: random stall bursts, a long hold-off on request, none in the last phase.
    // The hold-off ends on its own so the sender can finish.
    initial
    begin
        rsp_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_rsp = 1'b0;
                rsp_bus.ready <= 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                rsp_bus.ready <= 1'b1;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    // Checks each accepted response word against the oldest expected layout.
    always @(posedge clk)
    begin
        ypb_pkg::out_word_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (layout_queue.size() == 0)
            begin
                report_mismatch("unexpected response word", 1, 0);
            end
            else
            begin
                want = layout_queue.pop_front();
                if (rsp_bus.format_ok !== want.format_ok)
                    report_mismatch("format_ok", rsp_bus.format_ok, want.format_ok);
                if (rsp_bus.luma_stride !== want.luma_stride)
                    report_mismatch("luma_stride", rsp_bus.luma_stride, want.luma_stride);
                if (rsp_bus.first_chroma_stride !== want.first_chroma_stride)
                    report_mismatch("first_chroma_stride", rsp_bus.first_chroma_stride,
                                    want.first_chroma_stride);
                if (rsp_bus.second_chroma_stride !== want.second_chroma_stride)
                    report_mismatch("second_chroma_stride", rsp_bus.second_chroma_stride,
                                    want.second_chroma_stride);
                if (rsp_bus.first_chroma_offset !== want.first_chroma_offset)
                    report_mismatch("first_chroma_offset", rsp_bus.first_chroma_offset,
                                    want.first_chroma_offset);
                if (rsp_bus.second_chroma_offset !== want.second_chroma_offset)
                    report_mismatch("second_chroma_offset", rsp_bus.second_chroma_offset,
                                    want.second_chroma_offset);
                if (rsp_bus.plane_count !== want.plane_count)
                    report_mismatch("plane_count", rsp_bus.plane_count, want.plane_count);
                if (rsp_bus.buffer_bytes !== want.buffer_bytes)
                    report_mismatch("buffer_bytes", rsp_bus.buffer_bytes, want.buffer_bytes);
                words_checked++;
            end
        end
    end

    // Main sequence: reset, then each test in turn, then drain and report.
    initial
    begin
        error_count      = 0;
        words_sent       = 0;
        words_checked    = 0;
        unsupported_seen = 0;
        quiet_phase      = 1'b0;
        hold_rsp         = 1'b0;
        rst_n            = 1'b0;
        req_bus.valid        <= 1'b0;
        req_bus.pixel_format <= '0;
        req_bus.pic_width    <= '0;
        req_bus.pic_height   <= '0;
        req_bus.width_align  <= '0;
        req_bus.height_align <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random(340);
        test_streaming(100);

        // Drain, then keep watching for any stray word.
        wait (layout_queue.size() == 0);
        repeat (80) @(posedge clk);

        $display("Sent %0d request words across all formats, %0d of them unsupported;",
                 words_sent, unsupported_seen);
        $display("checked %0d response words under stalls, back-pressure and full rate.",
                 words_checked);
        if (error_count == 0 && layout_queue.size() == 0)
            $display("PASS yuv_picture_buffer_layout");
        else
            $display("FAIL yuv_picture_buffer_layout");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #2ms;
        $display("FAIL yuv_picture_buffer_layout");
        $finish;
    end

endmodule

### sim.f
sv/ypb_pkg.sv
sv/ypb_if.sv
sv/ypb_div.sv
sv/ypb_stride.sv
sv/ypb_size.sv
sv/ypb_skid.sv
sv/yuv_picture_buffer_layout.sv
tb/ypb_tb_if.sv
tb/tb_yuv_picture_buffer_layout.sv
